FILE: hw/rtl/sqe_pkg.sv
// Shared types and constants for the shadow quad extruder.
`timescale 1ns / 1ps

package sqe_pkg;

   localparam int COORD_W  = 24;
   localparam int SHADOW_W = 10;
   localparam int SIZE_W   = 8;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = 24'sh7FFFFF;
   localparam coord_type COORD_MIN = 24'sh800000;

   localparam logic [SHADOW_W-1:0] SHADOW_RESET = 10'd30;
   localparam logic [SIZE_W-1:0]   SIZE_RESET   = 8'd20;

   localparam logic [1:0] LAST_EDGE = 2'd3;

   typedef enum logic {
      CSR_SHADOW_LENGTH = 1'b0,
      CSR_CASTER_SIZE   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       final_quad;
      logic [1:0] edge_number;
      coord_type  ax;
      coord_type  ay;
   } quad_head_type;

   typedef struct packed {
      coord_type bx;
      coord_type by;
   } quad_tail_type;

endpackage

FILE: hw/rtl/sqe_isqrt.sv
// Pipelined integer square root with remainder, SP result bits per stage.
`timescale 1ns / 1ps

module sqe_isqrt #(
   parameter int W  = 50,
   parameter int SP = 2,
   parameter int TW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [W-1:0]    in_n,
   input  logic [TW-1:0]   in_tag,
   output logic            out_valid,
   output logic [W/2-1:0]  out_root,
   output logic [W-1:0]    out_rem,
   output logic [TW-1:0]   out_tag
);

   localparam int NB = W / 2;
   localparam int NS = (NB + SP - 1) / SP;

   logic          v_ff [NS];
   logic [W-1:0]  n_ff [NS];
   logic [W-1:0]  r_ff [NS];
   logic [TW-1:0] t_ff [NS];

   logic          v_in [NS];
   logic [TW-1:0] t_in [NS];
   logic [W-1:0]  n_sel [NS];
   logic [W-1:0]  r_sel [NS];
   logic [W-1:0]  n_in [NS];
   logic [W-1:0]  r_in [NS];
   logic [W-1:0]  bit_c;

   always_comb begin
      bit_c = '0;
      v_in[0]  = in_valid;
      t_in[0]  = in_tag;
      n_sel[0] = in_n;
      r_sel[0] = '0;
      for (int s = 1; s < NS; s++) begin
         v_in[s]  = v_ff[s-1];
         t_in[s]  = t_ff[s-1];
         n_sel[s] = n_ff[s-1];
         r_sel[s] = r_ff[s-1];
      end
      for (int s = 0; s < NS; s++) begin
         n_in[s] = n_sel[s];
         r_in[s] = r_sel[s];
         for (int i = 0; i < SP; i++) begin
            if (s * SP + i < NB) begin
               bit_c = W'(1) << (W - 2 - 2 * (s * SP + i));
               if (n_in[s] >= r_in[s] + bit_c) begin
                  n_in[s] = n_in[s] - (r_in[s] + bit_c);
                  r_in[s] = (r_in[s] >> 1) + bit_c;
               end else begin
                  r_in[s] = r_in[s] >> 1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) v_ff[s] <= 1'b0;
      end else if (adv) begin
         for (int s = 0; s < NS; s++) v_ff[s] <= v_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NS; s++) begin
            n_ff[s] <= n_in[s];
            r_ff[s] <= r_in[s];
            t_ff[s] <= t_in[s];
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_root  = r_ff[NS-1][W/2-1:0];
   assign out_rem   = n_ff[NS-1];
   assign out_tag   = t_ff[NS-1];

endmodule

FILE: hw/rtl/sqe_div.sv
// Pipelined restoring divider, SP quotient bits per stage.
`timescale 1ns / 1ps

module sqe_div #(
   parameter int DW = 25,
   parameter int QW = 20,
   parameter int SP = 2,
   parameter int TW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [DW+QW-1:0] in_num,
   input  logic [DW-1:0]   in_den,
   input  logic [TW-1:0]   in_tag,
   output logic            out_valid,
   output logic [QW-1:0]   out_quot,
   output logic [TW-1:0]   out_tag
);

   localparam int NS = (QW + SP - 1) / SP;

   logic          v_ff [NS];
   logic [DW-1:0] rem_ff [NS];
   logic [QW-1:0] low_ff [NS];
   logic [DW-1:0] den_ff [NS];
   logic [TW-1:0] t_ff [NS];

   logic          v_in [NS];
   logic [TW-1:0] t_in [NS];
   logic [DW-1:0] den_in [NS];
   logic [DW-1:0] rem_sel [NS];
   logic [QW-1:0] low_sel [NS];
   logic [DW-1:0] rem_in [NS];
   logic [QW-1:0] low_in [NS];
   logic [DW:0]   top_c;

   always_comb begin
      top_c      = '0;
      v_in[0]    = in_valid;
      t_in[0]    = in_tag;
      den_in[0]  = in_den;
      rem_sel[0] = in_num[DW+QW-1:QW];
      low_sel[0] = in_num[QW-1:0];
      for (int s = 1; s < NS; s++) begin
         v_in[s]    = v_ff[s-1];
         t_in[s]    = t_ff[s-1];
         den_in[s]  = den_ff[s-1];
         rem_sel[s] = rem_ff[s-1];
         low_sel[s] = low_ff[s-1];
      end
      for (int s = 0; s < NS; s++) begin
         rem_in[s] = rem_sel[s];
         low_in[s] = low_sel[s];
         for (int i = 0; i < SP; i++) begin
            if (s * SP + i < QW) begin
               top_c     = {rem_in[s], low_in[s][QW-1]};
               low_in[s] = low_in[s] << 1;
               if (top_c >= {1'b0, den_in[s]}) begin
                  rem_in[s]    = DW'(top_c - {1'b0, den_in[s]});
                  low_in[s][0] = 1'b1;
               end else begin
                  rem_in[s] = top_c[DW-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) v_ff[s] <= 1'b0;
      end else if (adv) begin
         for (int s = 0; s < NS; s++) v_ff[s] <= v_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NS; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            den_ff[s] <= den_in[s];
            t_ff[s]   <= t_in[s];
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_quot  = low_ff[NS-1];
   assign out_tag   = t_ff[NS-1];

endmodule

FILE: hw/rtl/sqe_lane.sv
// Extrusion of one point away from the viewer: distance, root, scale, divide, saturate.
`timescale 1ns / 1ps

module sqe_lane #(
   parameter int FRAC_BITS = 8,
   parameter int TW        = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  sqe_pkg::coord_type         in_px,
   input  sqe_pkg::coord_type         in_py,
   input  sqe_pkg::coord_type         in_vx,
   input  sqe_pkg::coord_type         in_vy,
   input  logic [TW-1:0]              in_tag,
   input  logic [sqe_pkg::SHADOW_W-1:0] shadow_length,
   output logic                       out_valid,
   output logic [TW-1:0]              out_tag,
   output sqe_pkg::coord_type         out_fx,
   output sqe_pkg::coord_type         out_fy
);

   localparam int CW   = sqe_pkg::COORD_W;
   localparam int KW   = sqe_pkg::SHADOW_W + FRAC_BITS;
   localparam int QW   = KW + 2;
   localparam int LW   = CW + 1;
   localparam int SQW  = 2 * LW;
   localparam int NW   = LW + QW;
   localparam int PW   = CW + KW;
   localparam int SUMW = (QW + 2 > CW + 2) ? QW + 2 : CW + 2;
   localparam int STW  = TW + 4 * CW + 2;
   localparam int XTW  = TW + 2 * CW + 1;

   // stage 1: difference and magnitude
   logic signed [CW:0] dx_c, dy_c;
   logic [CW:0]        mx_c, my_c;

   logic               s1_v_ff;
   logic [TW-1:0]      s1_tag_ff;
   sqe_pkg::coord_type s1_px_ff, s1_py_ff;
   logic               s1_sx_ff, s1_sy_ff;
   logic [CW-1:0]      s1_mx_ff, s1_my_ff;

   assign dx_c = {in_px[CW-1], in_px} - {in_vx[CW-1], in_vx};
   assign dy_c = {in_py[CW-1], in_py} - {in_vy[CW-1], in_vy};
   assign mx_c = dx_c[CW] ? -dx_c : dx_c;
   assign my_c = dy_c[CW] ? -dy_c : dy_c;

   // stage 2: squares
   logic               s2_v_ff;
   logic [TW-1:0]      s2_tag_ff;
   sqe_pkg::coord_type s2_px_ff, s2_py_ff;
   logic               s2_sx_ff, s2_sy_ff;
   logic [CW-1:0]      s2_mx_ff, s2_my_ff;
   logic [2*CW-1:0]    s2_qx_ff, s2_qy_ff;
   logic [2*CW-1:0]    qx_in, qy_in;

   assign qx_in = s1_mx_ff * s1_mx_ff;
   assign qy_in = s1_my_ff * s1_my_ff;

   // stage 3: squared distance
   logic               s3_v_ff;
   logic [STW-1:0]     s3_tag_ff;
   logic [SQW-1:0]     s3_dd_ff;

   // root
   logic               rt_v;
   logic [LW-1:0]      rt_root;
   logic [SQW-1:0]     rt_rem;
   logic [STW-1:0]     rt_tag;

   logic [TW-1:0]      rt_t;
   sqe_pkg::coord_type rt_px, rt_py;
   logic               rt_sx, rt_sy;
   logic [CW-1:0]      rt_mx, rt_my;

   // stage 4: rounded length and scaled magnitudes
   logic               s4_v_ff;
   logic [XTW-1:0]     s4_xt_ff;
   logic               s4_sy_ff;
   logic [LW-1:0]      s4_len_ff;
   logic [PW-1:0]      s4_px_ff, s4_py_ff;
   logic [LW-1:0]      len_in;
   logic [KW-1:0]      k_c;

   assign k_c    = KW'(shadow_length) << FRAC_BITS;
   assign len_in = rt_root + LW'(rt_rem > SQW'(rt_root));

   // stage 5: rounded numerators
   logic               s5_v_ff;
   logic [XTW-1:0]     s5_xt_ff;
   logic               s5_sy_ff;
   logic [LW-1:0]      s5_len_ff;
   logic [NW-1:0]      s5_nx_ff, s5_ny_ff;

   // divide
   logic               dx_v;
   logic [QW-1:0]      dx_q, dy_q;
   logic [XTW-1:0]     dx_tag;
   logic               dy_tag;

   logic [TW-1:0]      fin_t;
   sqe_pkg::coord_type fin_px, fin_py;
   logic               fin_sx;

   // stage 6: offset, add and saturate
   logic signed [SUMW-1:0] offx_c, offy_c, sumx_c, sumy_c;
   sqe_pkg::coord_type     fx_in, fy_in;

   logic               s6_v_ff;
   logic [TW-1:0]      s6_tag_ff;
   sqe_pkg::coord_type s6_fx_ff, s6_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= rt_v;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= dx_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff <= in_tag;
         s1_px_ff  <= in_px;
         s1_py_ff  <= in_py;
         s1_sx_ff  <= dx_c[CW];
         s1_sy_ff  <= dy_c[CW];
         s1_mx_ff  <= mx_c[CW-1:0];
         s1_my_ff  <= my_c[CW-1:0];

         s2_tag_ff <= s1_tag_ff;
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         s2_sx_ff  <= s1_sx_ff;
         s2_sy_ff  <= s1_sy_ff;
         s2_mx_ff  <= s1_mx_ff;
         s2_my_ff  <= s1_my_ff;
         s2_qx_ff  <= qx_in;
         s2_qy_ff  <= qy_in;

         s3_tag_ff <= {s2_tag_ff, s2_px_ff, s2_py_ff, s2_sx_ff, s2_sy_ff, s2_mx_ff, s2_my_ff};
         s3_dd_ff  <= SQW'(s2_qx_ff) + SQW'(s2_qy_ff);

         s4_xt_ff  <= {rt_t, rt_px, rt_py, rt_sx};
         s4_sy_ff  <= rt_sy;
         s4_len_ff <= len_in;
         s4_px_ff  <= rt_mx * k_c;
         s4_py_ff  <= rt_my * k_c;

         s5_xt_ff  <= s4_xt_ff;
         s5_sy_ff  <= s4_sy_ff;
         s5_len_ff <= s4_len_ff;
         s5_nx_ff  <= NW'(s4_px_ff) + NW'(s4_len_ff >> 1);
         s5_ny_ff  <= NW'(s4_py_ff) + NW'(s4_len_ff >> 1);

         s6_tag_ff <= fin_t;
         s6_fx_ff  <= fx_in;
         s6_fy_ff  <= fy_in;
      end
   end

   sqe_isqrt #(.W(SQW), .SP(2), .TW(STW)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s3_v_ff),
      .in_n     (s3_dd_ff),
      .in_tag   (s3_tag_ff),
      .out_valid(rt_v),
      .out_root (rt_root),
      .out_rem  (rt_rem),
      .out_tag  (rt_tag)
   );

   assign {rt_t, rt_px, rt_py, rt_sx, rt_sy, rt_mx, rt_my} = rt_tag;

   sqe_div #(.DW(LW), .QW(QW), .SP(2), .TW(XTW)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s5_v_ff),
      .in_num   (s5_nx_ff),
      .in_den   (s5_len_ff),
      .in_tag   (s5_xt_ff),
      .out_valid(dx_v),
      .out_quot (dx_q),
      .out_tag  (dx_tag)
   );

   sqe_div #(.DW(LW), .QW(QW), .SP(2), .TW(1)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s5_v_ff),
      .in_num   (s5_ny_ff),
      .in_den   (s5_len_ff),
      .in_tag   (s5_sy_ff),
      .out_valid(),
      .out_quot (dy_q),
      .out_tag  (dy_tag)
   );

   assign {fin_t, fin_px, fin_py, fin_sx} = dx_tag;

   always_comb begin
      offx_c = fin_sx ? -$signed(SUMW'(dx_q)) : $signed(SUMW'(dx_q));
      offy_c = dy_tag ? -$signed(SUMW'(dy_q)) : $signed(SUMW'(dy_q));
      sumx_c = SUMW'(fin_px) + offx_c;
      sumy_c = SUMW'(fin_py) + offy_c;
      if (sumx_c > SUMW'(sqe_pkg::COORD_MAX)) begin
         fx_in = sqe_pkg::COORD_MAX;
      end else if (sumx_c < SUMW'(sqe_pkg::COORD_MIN)) begin
         fx_in = sqe_pkg::COORD_MIN;
      end else begin
         fx_in = sumx_c[CW-1:0];
      end
      if (sumy_c > SUMW'(sqe_pkg::COORD_MAX)) begin
         fy_in = sqe_pkg::COORD_MAX;
      end else if (sumy_c < SUMW'(sqe_pkg::COORD_MIN)) begin
         fy_in = sqe_pkg::COORD_MIN;
      end else begin
         fy_in = sumy_c[CW-1:0];
      end
   end

   assign out_valid = s6_v_ff;
   assign out_tag   = s6_tag_ff;
   assign out_fx    = s6_fx_ff;
   assign out_fy    = s6_fy_ff;

endmodule

FILE: hw/rtl/shadow_quad_extruder.sv
// Top level: caster intake, edge sequencer, two extrusion lanes, config registers.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_tvalid/tready  | tdata: caster_left, caster_top, viewer_x, viewer_y
//   rsp     | out | rsp_tvalid/tready  | tdata: 8 coords, tuser: edge_number, tlast: final_quad
//   csr     | in  | csr_valid/ready    | csr_index, csr_data
//
// The sequencer issues one edge per cycle while rsp is not stalled; skipped edges leave
// a bubble. After a caster is accepted, its quads pass the lane stages, among them the
// 2-bit-per-stage square root and divider pipelines.
// Synchronous reset clears valid bits and sets config to its defaults (shadow length 30, caster size 20).
// A stall on rsp freezes every stage; no item is lost or repeated.
`timescale 1ns / 1ps

module shadow_quad_extruder #(
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // caster_left, caster_top, viewer_x, viewer_y
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // near_a_x, near_a_y, near_b_x, near_b_y,
                                     // far_a_x, far_a_y, far_b_x, far_b_y
   output logic [1:0]   rsp_tuser,   // edge_number
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [9:0]   csr_data
);

   localparam int CW = sqe_pkg::COORD_W;
   localparam int HW = $bits(sqe_pkg::quad_head_type);
   localparam int BW = $bits(sqe_pkg::quad_tail_type);

   logic [sqe_pkg::SHADOW_W-1:0] shadow_length_ff;
   logic [sqe_pkg::SIZE_W-1:0]   caster_size_ff;

   logic               busy_ff;
   logic [1:0]         edge_ff;
   logic [3:0]         skip_ff;
   logic [1:0]         last_ff;
   sqe_pkg::coord_type l_ff, t_ff, r_ff, b_ff, vx_ff, vy_ff;

   logic               adv;
   logic               accept;
   sqe_pkg::coord_type cl_c, ct_c, cvx_c, cvy_c, r_in, b_in;
   logic signed [CW+1:0] size_c, rsum_c, bsum_c;
   logic [3:0]         eq_c, skip_in;
   logic [1:0]         last_in;

   sqe_pkg::quad_head_type head_c, head_o;
   sqe_pkg::quad_tail_type tail_c, tail_o;
   logic               issue_v;
   sqe_pkg::coord_type fax, fay, fbx, fby;
   logic               lane_a_v;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_length_ff <= sqe_pkg::SHADOW_RESET;
         caster_size_ff   <= sqe_pkg::SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sqe_pkg::CSR_SHADOW_LENGTH: shadow_length_ff <= csr_data;
            sqe_pkg::CSR_CASTER_SIZE:   caster_size_ff   <= csr_data[sqe_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = !busy_ff || (adv && edge_ff == sqe_pkg::LAST_EDGE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cl_c   = req_tdata[CW-1:0];
      ct_c   = req_tdata[2*CW-1:CW];
      cvx_c  = req_tdata[3*CW-1:2*CW];
      cvy_c  = req_tdata[4*CW-1:3*CW];
      size_c = $signed((CW+2)'(caster_size_ff) << COORD_FRAC_BITS);
      rsum_c = (CW+2)'(cl_c) + size_c;
      bsum_c = (CW+2)'(ct_c) + size_c;
      if (rsum_c > (CW+2)'(sqe_pkg::COORD_MAX)) r_in = sqe_pkg::COORD_MAX;
      else r_in = rsum_c[CW-1:0];
      if (bsum_c > (CW+2)'(sqe_pkg::COORD_MAX)) b_in = sqe_pkg::COORD_MAX;
      else b_in = bsum_c[CW-1:0];
      eq_c[0] = (cl_c == cvx_c) && (ct_c == cvy_c);
      eq_c[1] = (r_in == cvx_c) && (ct_c == cvy_c);
      eq_c[2] = (r_in == cvx_c) && (b_in == cvy_c);
      eq_c[3] = (cl_c == cvx_c) && (b_in == cvy_c);
      for (int e = 0; e < 4; e++) skip_in[e] = eq_c[e] || eq_c[(e + 1) % 4];
      last_in = '0;
      for (int e = 0; e < 4; e++) begin
         if (!skip_in[e]) last_in = 2'(e);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         edge_ff <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         edge_ff <= '0;
      end else if (busy_ff && adv) begin
         edge_ff <= edge_ff + 2'd1;
         if (edge_ff == sqe_pkg::LAST_EDGE) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         l_ff    <= cl_c;
         t_ff    <= ct_c;
         r_ff    <= r_in;
         b_ff    <= b_in;
         vx_ff   <= cvx_c;
         vy_ff   <= cvy_c;
         skip_ff <= skip_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      issue_v            = busy_ff && !skip_ff[edge_ff];
      head_c.final_quad  = (edge_ff == last_ff);
      head_c.edge_number = edge_ff;
      head_c.ax          = (edge_ff == 2'd1 || edge_ff == 2'd2) ? r_ff : l_ff;
      head_c.ay          = edge_ff[1] ? b_ff : t_ff;
      tail_c.bx          = (edge_ff == 2'd0 || edge_ff == 2'd1) ? r_ff : l_ff;
      tail_c.by          = (edge_ff == 2'd1 || edge_ff == 2'd2) ? b_ff : t_ff;
   end

   sqe_lane #(.FRAC_BITS(COORD_FRAC_BITS), .TW(HW)) u_lane_a (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (issue_v),
      .in_px        (head_c.ax),
      .in_py        (head_c.ay),
      .in_vx        (vx_ff),
      .in_vy        (vy_ff),
      .in_tag       (head_c),
      .shadow_length(shadow_length_ff),
      .out_valid    (lane_a_v),
      .out_tag      (head_o),
      .out_fx       (fax),
      .out_fy       (fay)
   );

   sqe_lane #(.FRAC_BITS(COORD_FRAC_BITS), .TW(BW)) u_lane_b (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (issue_v),
      .in_px        (tail_c.bx),
      .in_py        (tail_c.by),
      .in_vx        (vx_ff),
      .in_vy        (vy_ff),
      .in_tag       (tail_c),
      .shadow_length(shadow_length_ff),
      .out_valid    (),
      .out_tag      (tail_o),
      .out_fx       (fbx),
      .out_fy       (fby)
   );

   assign rsp_tvalid = lane_a_v;
   assign rsp_tdata  = {fby, fbx, fay, fax, tail_o.by, tail_o.bx, head_o.ay, head_o.ax};
   assign rsp_tuser  = head_o.edge_number;
   assign rsp_tlast  = head_o.final_quad;

endmodule
